FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ECD_ASSERT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// same-cycle implication
`define ECD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ECD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/ecd_pkg.sv
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared constants for the eye-closure drowsiness monitor.
// ----------------------------------------------------------------------------
package ecd_pkg;

   // default sizing
   localparam int DEF_MAX_AVG_WINDOW    = 16;
   localparam int DEF_MAX_CLOSED_WINDOW = 32;
   localparam int DEF_CLOSED_PRELOAD    = 10;
   localparam int DEF_REFILL_COUNT      = 5;

   // register file
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_ADDR_W-1:0] CSR_AVG_LEN      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CLOSED_LEN   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CLOSED_LIMIT = 2'd2;

   localparam int AVG_LEN_W      = 5;
   localparam int CLOSED_LEN_W   = 6;
   localparam int CLOSED_LIMIT_W = 4;

   localparam logic [AVG_LEN_W-1:0]      AVG_LEN_RST      = 5'd10;
   localparam logic [CLOSED_LEN_W-1:0]   CLOSED_LEN_RST   = 6'd20;
   localparam logic [CLOSED_LIMIT_W-1:0] CLOSED_LIMIT_RST = 4'd1;

   // limit is in tenths
   localparam int ALARM_SCALE = 10;

   // last issued motor command
   localparam logic [1:0] MOTOR_NONE = 2'd0;
   localparam logic [1:0] MOTOR_MED  = 2'd1;
   localparam logic [1:0] MOTOR_SLOW = 2'd2;
   localparam logic [1:0] MOTOR_PULL = 2'd3;

   // command field encoding
   localparam logic CMD_MED  = 1'b0;
   localparam logic CMD_SLOW = 1'b1;

endpackage

FILE: hw/rtl/ecd_chan_if.sv
// ----------------------------------------------------------------------------
// ecd_chan_if
// Valid/ready channels for eye-state requests and monitor responses.
// ----------------------------------------------------------------------------
interface ecd_req_if;
   logic valid;
   logic ready;
   logic eye_open;

   modport source (output valid, output eye_open, input ready);
   modport sink   (input valid, input eye_open, output ready);
endinterface

interface ecd_rsp_if;
   logic valid;
   logic ready;
   logic eyes_avg;
   logic motor_valid;
   logic motor_cmd;
   logic pullover;

   modport source (output valid, output eyes_avg, output motor_valid,
                   output motor_cmd, output pullover, input ready);
   modport sink   (input valid, input eyes_avg, input motor_valid,
                   input motor_cmd, input pullover, output ready);
endinterface

FILE: hw/rtl/eye_closure_drowsiness_monitor_top.sv
// ----------------------------------------------------------------------------
// eye_closure_drowsiness_monitor_top
// Usage:
//   req_if carries one eye-state bit per video frame (1 open, 0 closed).
//   rsp_if returns one response per request: rounded mean of the averaging
//   window, an optional medium/slow motor command (sent only on change) and
//   the closed-eye pull-over alarm.
//   csr_* writes the three length/limit registers; write only while idle.
//   Path: an accepted request is held in the input register, then its
//   response in the response register.
//   Throughput: one request per cycle while rsp_if.ready holds; running fill
//   and ones counts let each bit update both windows between the registers.
//   Reset: synchronous; windows empty except the closed-eye window preload
//   of ones, no motor command issued yet, registers at their defaults.
//   Stall: a held response keeps one more request in the input register;
//   req_if.ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module eye_closure_drowsiness_monitor_top #(
   parameter int MAX_AVG_WINDOW    = ecd_pkg::DEF_MAX_AVG_WINDOW,
   parameter int MAX_CLOSED_WINDOW = ecd_pkg::DEF_MAX_CLOSED_WINDOW,
   parameter int CLOSED_PRELOAD    = ecd_pkg::DEF_CLOSED_PRELOAD,
   parameter int REFILL_COUNT      = ecd_pkg::DEF_REFILL_COUNT
) (
   input  logic                            clock,
   input  logic                            reset,
   ecd_req_if.sink                         req_if,
   ecd_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [ecd_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [ecd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ecd_pkg::*;

   localparam int AVG_FW = $clog2(MAX_AVG_WINDOW + 2);
   localparam int CL_FW  = $clog2(MAX_CLOSED_WINDOW + 2);

   logic [AVG_LEN_W-1:0]      avg_len_ff, avg_len_in;
   logic [CLOSED_LEN_W-1:0]   cl_len_ff, cl_len_in;
   logic [CLOSED_LIMIT_W-1:0] cl_limit_ff, cl_limit_in;

   logic              step;
   logic              eye_bit;
   logic              refill;
   logic [AVG_FW-1:0] avg_fill;
   logic [AVG_FW-1:0] avg_ones;
   logic [CL_FW-1:0]  cl_fill;
   logic [CL_FW-1:0]  cl_ones;

   always_comb begin
      avg_len_in  = avg_len_ff;
      cl_len_in   = cl_len_ff;
      cl_limit_in = cl_limit_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_AVG_LEN: begin
               avg_len_in = csr_wdata[AVG_LEN_W-1:0];
            end
            CSR_CLOSED_LEN: begin
               cl_len_in = csr_wdata[CLOSED_LEN_W-1:0];
            end
            CSR_CLOSED_LIMIT: begin
               cl_limit_in = csr_wdata[CLOSED_LIMIT_W-1:0];
            end
            default: begin
               avg_len_in = avg_len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_len_ff  <= AVG_LEN_RST;
         cl_len_ff   <= CLOSED_LEN_RST;
         cl_limit_ff <= CLOSED_LIMIT_RST;
      end else begin
         avg_len_ff  <= avg_len_in;
         cl_len_ff   <= cl_len_in;
         cl_limit_ff <= cl_limit_in;
      end
   end

   ecd_window #(
      .DEPTH   (MAX_AVG_WINDOW),
      .PRELOAD (0),
      .REFILL  (1),
      .MIN_LEN (1),
      .CFG_W   (AVG_LEN_W),
      .FW      (AVG_FW)
   ) u_avg_win (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .eye_bit  (eye_bit),
      .refill   (1'b0),
      .len_cfg  (avg_len_ff),
      .fill_nxt (avg_fill),
      .ones_nxt (avg_ones)
   );

   ecd_window #(
      .DEPTH   (MAX_CLOSED_WINDOW),
      .PRELOAD (CLOSED_PRELOAD),
      .REFILL  (REFILL_COUNT),
      .MIN_LEN (REFILL_COUNT),
      .CFG_W   (CLOSED_LEN_W),
      .FW      (CL_FW)
   ) u_closed_win (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .eye_bit  (eye_bit),
      .refill   (refill),
      .len_cfg  (cl_len_ff),
      .fill_nxt (cl_fill),
      .ones_nxt (cl_ones)
   );

   ecd_ctrl #(
      .AVG_FW (AVG_FW),
      .CL_FW  (CL_FW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req          (req_if),
      .rsp          (rsp_if),
      .closed_limit (cl_limit_ff),
      .avg_fill     (avg_fill),
      .avg_ones     (avg_ones),
      .cl_fill      (cl_fill),
      .cl_ones      (cl_ones),
      .step         (step),
      .eye_bit      (eye_bit),
      .refill       (refill)
   );

endmodule

FILE: hw/rtl/ecd_window.sv
// ----------------------------------------------------------------------------
// ecd_window
// Bit window with running fill and ones count; optional drop-and-refill.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ecd_window #(
   parameter int DEPTH   = 16,
   parameter int PRELOAD = 0,
   parameter int REFILL  = 1,
   parameter int MIN_LEN = 1,
   parameter int CFG_W   = 5,
   parameter int FW      = $clog2(DEPTH + 2)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             eye_bit,
   input  logic             refill,
   input  logic [CFG_W-1:0] len_cfg,
   output logic [FW-1:0]    fill_nxt,
   output logic [FW-1:0]    ones_nxt
);
   localparam int CW = (CFG_W > FW) ? CFG_W : FW;
   localparam int PE = (PRELOAD > DEPTH) ? DEPTH : PRELOAD;
   localparam logic [DEPTH-1:0] PRE_VEC = {DEPTH{1'b1}} >> (DEPTH - PE);

   logic [DEPTH-1:0]        win_ff, win_in;
   logic [FW-1:0]           fill_ff, fill_in;
   logic [FW-1:0]           ones_ff, ones_in;

   logic [CW-1:0]           len_ext;
   logic [FW-1:0]           len_eff;
   logic [FW-1:0]           fill_plus;
   logic                    drop;
   logic [DEPTH:0]          pushed;
   logic [DEPTH-1:0]        win_push;
   logic [DEPTH+REFILL-1:0] ext;
   logic [DEPTH-1:0]        win_refill;
   logic [FW-1:0]           head_ones;

   always_comb begin
      len_ext = CW'(len_cfg);
      if (len_ext < CW'(MIN_LEN)) begin
         len_eff = FW'(MIN_LEN);
      end else if (len_ext > CW'(DEPTH)) begin
         len_eff = FW'(DEPTH);
      end else begin
         len_eff = FW'(len_ext);
      end

      fill_plus = fill_ff + FW'(1);
      drop      = fill_plus > len_eff;

      for (int i = 0; i <= DEPTH; i++) begin
         if (FW'(i) == fill_ff) begin
            pushed[i] = eye_bit;
         end else if (i < DEPTH) begin
            pushed[i] = win_ff[i];
         end else begin
            pushed[i] = 1'b0;
         end
      end
      win_push = drop ? pushed[DEPTH:1] : pushed[DEPTH-1:0];
      fill_nxt = drop ? fill_ff : fill_plus;
      ones_nxt = ones_ff + FW'(eye_bit) - FW'(drop & pushed[0]);

      // drop the oldest REFILL entries, append ones
      ext = {{REFILL{1'b1}}, win_push};
      for (int i = 0; i < DEPTH; i++) begin
         win_refill[i] = ((i + REFILL) < int'(fill_nxt)) ? ext[i + REFILL] : 1'b1;
      end
      head_ones = '0;
      for (int i = 0; i < REFILL; i++) begin
         head_ones = head_ones + FW'(win_push[i]);
      end

      win_in  = win_ff;
      fill_in = fill_ff;
      ones_in = ones_ff;
      if (step) begin
         fill_in = fill_nxt;
         if (refill) begin
            win_in  = win_refill;
            ones_in = ones_nxt - head_ones + FW'(REFILL);
         end else begin
            win_in  = win_push;
            ones_in = ones_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= PRE_VEC;
         fill_ff <= FW'(PE);
         ones_ff <= FW'(PE);
      end else begin
         win_ff  <= win_in;
         fill_ff <= fill_in;
         ones_ff <= ones_in;
      end
   end

   `ECD_ASSERT(a_count_bound, clock, reset, (ones_ff <= fill_ff) && (fill_ff <= FW'(DEPTH)))
   `ECD_ASSERT_NXT(a_refill_ones, clock, reset, step && refill, ones_ff >= FW'(REFILL))

endmodule

FILE: hw/rtl/ecd_ctrl.sv
// ----------------------------------------------------------------------------
// ecd_ctrl
// Request/response registers, mean and alarm tests, motor command tracking.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ecd_ctrl #(
   parameter int AVG_FW = 5,
   parameter int CL_FW  = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   ecd_req_if.sink                             req,
   ecd_rsp_if.source                           rsp,
   input  logic [ecd_pkg::CLOSED_LIMIT_W-1:0]  closed_limit,
   input  logic [AVG_FW-1:0]                   avg_fill,
   input  logic [AVG_FW-1:0]                   avg_ones,
   input  logic [CL_FW-1:0]                    cl_fill,
   input  logic [CL_FW-1:0]                    cl_ones,
   output logic                                step,
   output logic                                eye_bit,
   output logic                                refill
);
   import ecd_pkg::*;

   localparam int PW = CL_FW + CLOSED_LIMIT_W;

   logic       in_valid_ff, in_valid_in;
   logic       in_bit_ff, in_bit_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_avg_ff, rsp_avg_in;
   logic       rsp_mvalid_ff, rsp_mvalid_in;
   logic       rsp_cmd_ff, rsp_cmd_in;
   logic       rsp_pull_ff, rsp_pull_in;
   logic [1:0] last_motor_ff, last_motor_in;

   logic       avg_bit;
   logic       alarm;
   logic       mvalid;
   logic       mcmd;

   always_comb begin
      step      = in_valid_ff && (!rsp_valid_ff || rsp.ready);
      req.ready = !in_valid_ff || step;
      eye_bit   = in_bit_ff;

      avg_bit = {avg_ones, 1'b0} >= {1'b0, avg_fill};
      alarm   = (PW'(cl_ones) * PW'(ALARM_SCALE)) <= (PW'(closed_limit) * PW'(cl_fill));
      refill  = alarm;

      mvalid        = 1'b0;
      mcmd          = CMD_MED;
      last_motor_in = last_motor_ff;
      if (in_bit_ff) begin
         if (last_motor_ff != MOTOR_MED) begin
            mvalid        = 1'b1;
            last_motor_in = MOTOR_MED;
         end
      end else begin
         if (last_motor_ff != MOTOR_SLOW) begin
            mvalid        = 1'b1;
            mcmd          = CMD_SLOW;
            last_motor_in = MOTOR_SLOW;
         end
      end
      if (alarm) begin
         last_motor_in = MOTOR_PULL;
      end
      if (!step) begin
         last_motor_in = last_motor_ff;
      end

      in_valid_in = in_valid_ff;
      in_bit_in   = in_bit_ff;
      if (req.ready) begin
         in_valid_in = req.valid;
         in_bit_in   = req.eye_open;
      end

      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_avg_in    = rsp_avg_ff;
      rsp_mvalid_in = rsp_mvalid_ff;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_pull_in   = rsp_pull_ff;
      if (step) begin
         rsp_valid_in  = 1'b1;
         rsp_avg_in    = avg_bit;
         rsp_mvalid_in = mvalid;
         rsp_cmd_in    = mcmd;
         rsp_pull_in   = alarm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         last_motor_ff <= MOTOR_NONE;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_motor_ff <= last_motor_in;
      end
   end

   always_ff @(posedge clock) begin
      in_bit_ff     <= in_bit_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_mvalid_ff <= rsp_mvalid_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_pull_ff   <= rsp_pull_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.eyes_avg    = rsp_avg_ff;
   assign rsp.motor_valid = rsp_mvalid_ff;
   assign rsp.motor_cmd   = rsp_cmd_ff;
   assign rsp.pullover    = rsp_pull_ff;

   `ECD_ASSERT_IMP(a_stall_full, clock, reset, !req.ready, in_valid_ff && rsp_valid_ff)
   `ECD_ASSERT_IMP(a_pull_state, clock, reset, rsp_valid_ff && rsp_pull_ff, last_motor_ff == MOTOR_PULL)
   `ECD_ASSERT_IMP(a_cmd_quiet, clock, reset, rsp_valid_ff && !rsp_mvalid_ff, rsp_cmd_ff == CMD_MED)

endmodule
